>>> sv/jgph_pkg.sv
package jgph_pkg;

    localparam int CELL_W      = 29;
    localparam int POINT_W     = 32;
    localparam int SEED_W      = 64;
    localparam int THRESH_W    = 17;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 64;

    localparam int DEFAULT_CELL_SIZE = 6;

    localparam logic [SEED_W-1:0]   SEED_RESET   = '0;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd26214;

    localparam logic [CFG_INDEX_W-1:0] CFG_WORLD_SEED        = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DENSITY_THRESHOLD = 1'd1;

    localparam logic [63:0] GAMMA_K = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX1_K  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX2_K  = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] MULX_K  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MULZ_K  = 64'hC2B2_AE3D_27D4_EB4F;

    // The three partial products of 32-bit halves that make up the low 64 bits of a 64 by 64 product.
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
    } part_t;

    function automatic part_t mul_part(input logic [63:0] a, input logic [63:0] k);
        part_t p;
        p.ll = 64'(a[31:0]) * 64'(k[31:0]);
        p.lh = a[31:0] * k[63:32];
        p.hl = a[63:32] * k[31:0];
        return p;
    endfunction

    function automatic logic [63:0] mul_sum(input part_t p);
        logic [31:0] hi;
        hi = p.ll[63:32] + p.lh + p.hl;
        return {hi, p.ll[31:0]};
    endfunction

endpackage

>>> sv/jittered_grid_point_hash.sv
// Jittered grid point hash: each transaction on the cell channel carries one grid cell, and
// exactly one transaction follows on the point channel, in order. One cell is accepted every
// cycle while cell_stall is low. The datapath is a
// 17-stage pipeline: the two coordinate products and the four SplitMix64 multiplies are each
// split into 32-bit partial products over two stages, and the jitter modulo the cell size
// takes four stages (a fold of the hash into a narrow word, a reciprocal multiply, a
// subtraction and a final correction). A stall on the point channel holds the whole pipeline,
// so cell_stall follows point_stall whenever a result waits. Configuration writes take effect
// at once and are meant to be made while no transaction is in flight.
module jittered_grid_point_hash
    import jgph_pkg::*;
#(
    parameter int CELL_SIZE = DEFAULT_CELL_SIZE
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        cell_valid,
    output logic                        cell_stall,
    input  logic signed [CELL_W-1:0]    cell_x,
    input  logic signed [CELL_W-1:0]    cell_z,
    output logic                        point_valid,
    input  logic                        point_stall,
    output logic                        present,
    output logic signed [POINT_W-1:0]   point_x,
    output logic signed [POINT_W-1:0]   point_z
);

    localparam int NUM_STAGES = 17;
    localparam int BASE_LEN   = 16;
    localparam int PZ_LEN     = 6;
    localparam int HIT_LEN    = 4;

    localparam int CS_W   = $clog2(CELL_SIZE + 1);
    localparam int RE_W   = CS_W + 1;
    localparam int P16    = 65536 % CELL_SIZE;
    localparam int P32    = (P16 * P16) % CELL_SIZE;
    localparam int FOLD_W = $clog2(65536 * (2 * CELL_SIZE + 1));
    localparam int M_W    = FOLD_W + 1;
    localparam int PROD_W = FOLD_W + M_W;
    localparam logic [M_W-1:0] RECIP_M = M_W'((64'd1 << FOLD_W) / CELL_SIZE);

    logic                   en;
    logic [NUM_STAGES-1:0]  valid_reg;
    logic [NUM_STAGES-1:0]  valid_next;

    logic [SEED_W-1:0]      world_seed_reg;
    logic [THRESH_W-1:0]    density_threshold_reg;

    logic [31:0]            cx32;
    logic [31:0]            cz32;
    logic [63:0]            h;
    logic [PROD_W-1:0]      qx_prod;
    logic [PROD_W-1:0]      qz_prod;

    part_t                  px_reg, px_next;
    part_t                  pz_reg, pz_next;
    logic [31:0]            bx_reg [BASE_LEN];
    logic [31:0]            bx_next [BASE_LEN];
    logic [31:0]            bz_reg [BASE_LEN];
    logic [31:0]            bz_next [BASE_LEN];
    logic [63:0]            pzs_reg [PZ_LEN];
    logic [63:0]            pzs_next [PZ_LEN];
    logic                   hit_reg [HIT_LEN];
    logic                   hit_next [HIT_LEN];
    logic [63:0]            u_reg, u_next;
    logic [63:0]            v_reg, v_next;
    part_t                  m1_reg, m1_next;
    logic [63:0]            w_reg, w_next;
    part_t                  m2_reg, m2_next;
    logic [63:0]            y_reg, y_next;
    logic [63:0]            v2_reg, v2_next;
    part_t                  m3_reg, m3_next;
    logic [63:0]            w2_reg, w2_next;
    part_t                  m4_reg, m4_next;
    logic [63:0]            y2_reg, y2_next;
    logic [FOLD_W-1:0]      fx_reg, fx_next;
    logic [FOLD_W-1:0]      fz_reg, fz_next;
    logic [FOLD_W-1:0]      qx_reg, qx_next;
    logic [FOLD_W-1:0]      qz_reg, qz_next;
    logic [RE_W-1:0]        fxl_reg, fxl_next;
    logic [RE_W-1:0]        fzl_reg, fzl_next;
    logic [RE_W-1:0]        rex_reg, rex_next;
    logic [RE_W-1:0]        rez_reg, rez_next;
    logic [CS_W-1:0]        jx_reg, jx_next;
    logic [CS_W-1:0]        jz_reg, jz_next;
    logic                   present_reg, present_next;
    logic [POINT_W-1:0]     point_x_reg, point_x_next;
    logic [POINT_W-1:0]     point_z_reg, point_z_next;

    assign en          = !(valid_reg[NUM_STAGES-1] && point_stall);
    assign cell_stall  = !en;
    assign point_valid = valid_reg[NUM_STAGES-1];
    assign present     = present_reg;
    assign point_x     = point_x_reg;
    assign point_z     = point_z_reg;

    assign cx32    = 32'(cell_x);
    assign cz32    = 32'(cell_z);
    assign h       = y2_reg ^ (y2_reg >> 31);
    assign qx_prod = PROD_W'(fx_reg) * PROD_W'(RECIP_M);
    assign qz_prod = PROD_W'(fz_reg) * PROD_W'(RECIP_M);

    always_comb
    begin
        valid_next = {valid_reg[NUM_STAGES-2:0], cell_valid};

        px_next    = mul_part({32'd0, cx32}, MULX_K);
        pz_next    = mul_part({32'd0, cz32}, MULZ_K);
        bx_next[0] = cx32 * 32'(CELL_SIZE);
        bz_next[0] = cz32 * 32'(CELL_SIZE);
        for (int i = 1; i < BASE_LEN; i++)
        begin
            bx_next[i] = bx_reg[i-1];
            bz_next[i] = bz_reg[i-1];
        end

        u_next      = world_seed_reg ^ mul_sum(px_reg);
        pzs_next[0] = mul_sum(pz_reg);
        for (int i = 1; i < PZ_LEN; i++)
        begin
            pzs_next[i] = pzs_reg[i-1];
        end

        v_next  = u_reg + GAMMA_K;
        m1_next = mul_part(v_reg ^ (v_reg >> 30), MIX1_K);
        w_next  = mul_sum(m1_reg);
        m2_next = mul_part(w_reg ^ (w_reg >> 27), MIX2_K);
        y_next  = mul_sum(m2_reg);

        v2_next = (y_reg ^ (y_reg >> 31) ^ pzs_reg[PZ_LEN-1]) + GAMMA_K;
        m3_next = mul_part(v2_reg ^ (v2_reg >> 30), MIX1_K);
        w2_next = mul_sum(m3_reg);
        m4_next = mul_part(w2_reg ^ (w2_reg >> 27), MIX2_K);
        y2_next = mul_sum(m4_reg);

        // Fold the jitter words into a narrow value with the same residue modulo the cell size.
        hit_next[0] = {1'b0, h[15:0]} < density_threshold_reg;
        fx_next = FOLD_W'(h[63:48]) * FOLD_W'(P32) + FOLD_W'(h[47:32]) * FOLD_W'(P16)
                + FOLD_W'(h[31:16]);
        fz_next = FOLD_W'(h[63:48]) * FOLD_W'(P16) + FOLD_W'(h[47:32]);
        for (int i = 1; i < HIT_LEN; i++)
        begin
            hit_next[i] = hit_reg[i-1];
        end

        // The reciprocal quotient is exact or one short, so the remainder lies below twice the size.
        qx_next  = qx_prod[2*FOLD_W-1:FOLD_W];
        qz_next  = qz_prod[2*FOLD_W-1:FOLD_W];
        fxl_next = fx_reg[RE_W-1:0];
        fzl_next = fz_reg[RE_W-1:0];

        rex_next = fxl_reg - RE_W'(qx_reg[RE_W-1:0] * RE_W'(CELL_SIZE));
        rez_next = fzl_reg - RE_W'(qz_reg[RE_W-1:0] * RE_W'(CELL_SIZE));

        jx_next = (rex_reg >= RE_W'(CELL_SIZE)) ? CS_W'(rex_reg - RE_W'(CELL_SIZE))
                                                : CS_W'(rex_reg);
        jz_next = (rez_reg >= RE_W'(CELL_SIZE)) ? CS_W'(rez_reg - RE_W'(CELL_SIZE))
                                                : CS_W'(rez_reg);

        present_next = hit_reg[HIT_LEN-1];
        point_x_next = hit_reg[HIT_LEN-1] ? bx_reg[BASE_LEN-1] + POINT_W'(jx_reg) : '0;
        point_z_next = hit_reg[HIT_LEN-1] ? bz_reg[BASE_LEN-1] + POINT_W'(jz_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg             <= '0;
            world_seed_reg        <= SEED_RESET;
            density_threshold_reg <= THRESH_RESET;
        end
        else
        begin
            if (en)
            begin
                valid_reg <= valid_next;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_WORLD_SEED:        world_seed_reg        <= cfg_data;
                    CFG_DENSITY_THRESHOLD: density_threshold_reg <= cfg_data[THRESH_W-1:0];
                    default:               ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg      <= px_next;
            pz_reg      <= pz_next;
            bx_reg      <= bx_next;
            bz_reg      <= bz_next;
            pzs_reg     <= pzs_next;
            hit_reg     <= hit_next;
            u_reg       <= u_next;
            v_reg       <= v_next;
            m1_reg      <= m1_next;
            w_reg       <= w_next;
            m2_reg      <= m2_next;
            y_reg       <= y_next;
            v2_reg      <= v2_next;
            m3_reg      <= m3_next;
            w2_reg      <= w2_next;
            m4_reg      <= m4_next;
            y2_reg      <= y2_next;
            fx_reg      <= fx_next;
            fz_reg      <= fz_next;
            qx_reg      <= qx_next;
            qz_reg      <= qz_next;
            fxl_reg     <= fxl_next;
            fzl_reg     <= fzl_next;
            rex_reg     <= rex_next;
            rez_reg     <= rez_next;
            jx_reg      <= jx_next;
            jz_reg      <= jz_next;
            present_reg <= present_next;
            point_x_reg <= point_x_next;
            point_z_reg <= point_z_next;
        end
    end

    a_remainder_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[14] |-> (rex_reg < RE_W'(2 * CELL_SIZE)) && (rez_reg < RE_W'(2 * CELL_SIZE)))
        else $error("Remainder estimate out of range.");

    a_jitter_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[15] |-> (jx_reg < CS_W'(CELL_SIZE)) && (jz_reg < CS_W'(CELL_SIZE)))
        else $error("Jitter not below the cell size.");

    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !present |-> (point_x == '0) && (point_z == '0))
        else $error("Absent point carries a non-zero position.");

endmodule

>>> tb/jgph_point_checker.sv
module jgph_point_checker
    import jgph_pkg::*;
#(
    parameter int CELL_SIZE = DEFAULT_CELL_SIZE
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        cell_valid,
    input  logic                        cell_stall,
    input  logic [CELL_W-1:0]           cell_x,
    input  logic [CELL_W-1:0]           cell_z,
    input  logic                        point_valid,
    input  logic                        point_stall,
    input  logic                        present,
    input  logic [POINT_W-1:0]          point_x,
    input  logic [POINT_W-1:0]          point_z,
    output int                          errors,
    output int                          pending,
    output int                          cells_taken,
    output int                          points_taken
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               present;
        logic [POINT_W-1:0] x;
        logic [POINT_W-1:0] z;
    } point_t;

    logic [SEED_W-1:0]   seed;
    logic [THRESH_W-1:0] threshold;
    point_t              expected_points[$];

    function automatic logic [63:0] splitmix_round(input logic [63:0] v);
        logic [63:0] s;
        s = v + GAMMA_K;
        s = (s ^ (s >> 30)) * MIX1_K;
        s = (s ^ (s >> 27)) * MIX2_K;
        return s ^ (s >> 31);
    endfunction

    function automatic point_t predict_point(input logic [CELL_W-1:0] cx,
                                             input logic [CELL_W-1:0] cz);
        logic [63:0] wx;
        logic [63:0] wz;
        logic [63:0] h;
        logic [63:0] jx;
        logic [63:0] jz;
        point_t      p;
        wx = {{(64 - CELL_W){cx[CELL_W-1]}}, cx};
        wz = {{(64 - CELL_W){cz[CELL_W-1]}}, cz};
        h = splitmix_round(seed ^ ({32'b0, wx[31:0]} * MULX_K));
        h = splitmix_round(h ^ ({32'b0, wz[31:0]} * MULZ_K));
        p = '0;
        if ({1'b0, h[15:0]} < threshold)
        begin
            jx = (h >> 16) % 64'(CELL_SIZE);
            jz = (h >> 32) % 64'(CELL_SIZE);
            p.present = 1'b1;
            p.x = 32'(wx * 64'(CELL_SIZE) + jx);
            p.z = 32'(wz * 64'(CELL_SIZE) + jz);
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        point_t want;
        if (!rst_n)
        begin
            seed         <= SEED_RESET;
            threshold    <= THRESH_RESET;
            errors       = 0;
            pending      <= 0;
            cells_taken  <= 0;
            points_taken <= 0;
            expected_points.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_WORLD_SEED:        seed <= cfg_data;
                    CFG_DENSITY_THRESHOLD: threshold <= cfg_data[THRESH_W-1:0];
                    default:               ;
                endcase
            end
            if (point_valid && !point_stall)
            begin
                points_taken <= points_taken + 1;
                if (expected_points.size() == 0)
                begin
                    errors++;
                    $error("point transaction with no cell awaiting a result");
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (present !== want.present)
                    begin
                        errors++;
                        $error("present: expected %0d, actual %0d", want.present, present);
                    end
                    if (point_x !== want.x)
                    begin
                        errors++;
                        $error("point_x: expected %0d, actual %0d",
                               $signed(want.x), $signed(point_x));
                    end
                    if (point_z !== want.z)
                    begin
                        errors++;
                        $error("point_z: expected %0d, actual %0d",
                               $signed(want.z), $signed(point_z));
                    end
                end
            end
            if (cell_valid && !cell_stall)
            begin
                cells_taken <= cells_taken + 1;
                expected_points.push_back(predict_point(cell_x, cell_z));
            end
            pending <= expected_points.size();
        end
    end

endmodule

>>> tb/tb_jittered_grid_point_hash.sv
module tb_jittered_grid_point_hash
    import jgph_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 240;
    localparam int NUM_PHASES   = 8;

    localparam logic [CELL_W-1:0] CELL_MIN = {1'b1, {(CELL_W - 1){1'b0}}};
    localparam logic [CELL_W-1:0] CELL_MAX = {1'b0, {(CELL_W - 1){1'b1}}};
    localparam logic [CELL_W-1:0] CELL_NEG = {CELL_W{1'b1}};
    localparam logic [CELL_W-1:0] CELL_ONE = CELL_W'(1);
    localparam logic [CELL_W-1:0] CELL_ZERO = '0;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   cell_valid;
    logic                   cell_stall;
    logic [CELL_W-1:0]      cell_x;
    logic [CELL_W-1:0]      cell_z;
    logic                   point_valid;
    logic                   point_stall;
    logic                   present;
    logic [POINT_W-1:0]     point_x;
    logic [POINT_W-1:0]     point_z;

    int errors;
    int pending;
    int cells_taken;
    int points_taken;
    int idle_cycles = 0;
    int last_cells = 0;
    int last_points = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    jittered_grid_point_hash DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cell_valid  (cell_valid),
        .cell_stall  (cell_stall),
        .cell_x      (cell_x),
        .cell_z      (cell_z),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .present     (present),
        .point_x     (point_x),
        .point_z     (point_z)
    );

    jgph_point_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_x       (cell_x),
        .cell_z       (cell_z),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .present      (present),
        .point_x      (point_x),
        .point_z      (point_z),
        .errors       (errors),
        .pending      (pending),
        .cells_taken  (cells_taken),
        .points_taken (points_taken)
    );

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [CELL_W-1:0] random_cell();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return CELL_MIN;
            1:       return CELL_MAX;
            2:       return CELL_ZERO;
            3:       return CELL_NEG;
            4:       return CELL_W'($urandom_range(0, 40)) - CELL_W'(20);
            default: return CELL_W'($urandom());
        endcase
    endfunction

    task automatic send_cell(input logic [CELL_W-1:0] x, input logic [CELL_W-1:0] z,
                             input int gap);
        int taken;
        if (gap > 0)
        begin
            cell_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cell_valid = 1'b1;
        cell_x = x;
        cell_z = z;
        taken = cells_taken;
        do
            @(negedge clk);
        while (cells_taken == taken);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // The block is drained before any register changes, so that no cell in flight sees a
    // half-updated configuration.
    task automatic reconfigure(input logic [SEED_W-1:0] seed,
                               input logic [THRESH_W-1:0] threshold);
        cell_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        write_reg(CFG_WORLD_SEED, seed);
        write_reg(CFG_DENSITY_THRESHOLD, CFG_DATA_W'(threshold));
    endtask

    initial
    begin
        int run;
        point_stall = 1'b0;
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                              : $urandom_range(0, 12);
            point_stall = 1'b0;
            repeat (run) @(negedge clk);
            point_stall = 1'b1;
            repeat (idle_gap() + 1) @(negedge clk);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cells_taken != last_cells || points_taken != last_points)
                idle_cycles = 0;
            else
                idle_cycles++;
            last_cells = cells_taken;
            last_points = points_taken;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_jittered_grid_point_hash: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        logic [CELL_W-1:0]   corner[5];
        logic [THRESH_W-1:0] phase_threshold[NUM_PHASES];
        logic [SEED_W-1:0]   phase_seed;
        bit                  gapless;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_WORLD_SEED;
        cfg_data = '0;
        cell_valid = 1'b0;
        cell_x = '0;
        cell_z = '0;
        corner = '{CELL_MIN, CELL_MAX, CELL_ZERO, CELL_NEG, CELL_ONE};
        phase_threshold = '{17'd65535, 17'd1, THRESH_RESET,
                            THRESH_W'($urandom_range(0, 65536)), 17'd65536,
                            THRESH_W'($urandom_range(0, 65536)), 17'd32768,
                            THRESH_W'($urandom_range(0, 65536))};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < 5; i++)
        begin
            send_cell(corner[i], corner[4 - i], 0);
            send_cell(corner[i], corner[i], 1);
        end

        // Every cell holds a point, with the seed at its top value.
        reconfigure({SEED_W{1'b1}}, 17'd65536);
        send_cell(CELL_MIN, CELL_MIN, 0);
        send_cell(CELL_MAX, CELL_MAX, 0);
        send_cell(CELL_MIN, CELL_MAX, 0);
        send_cell(CELL_MAX, CELL_MIN, 0);
        send_cell(CELL_ZERO, CELL_ZERO, 0);
        send_cell(CELL_NEG, CELL_ONE, 0);

        // No cell holds a point.
        reconfigure('0, '0);
        send_cell(CELL_MIN, CELL_MAX, 0);
        send_cell(CELL_MAX, CELL_MIN, 0);
        send_cell(CELL_ZERO, CELL_NEG, 0);
        send_cell(CELL_ONE, CELL_ZERO, 0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p % 4)
                0:       phase_seed = '0;
                1:       phase_seed = {SEED_W{1'b1}};
                default: phase_seed = {$urandom(), $urandom()};
            endcase
            reconfigure(phase_seed, phase_threshold[p]);
            gapless = (p % 3 == 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_cell(random_cell(), random_cell(), gapless ? 0 : idle_gap());
        end

        cell_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_jittered_grid_point_hash: done, clean");
        else
            $display("tb_jittered_grid_point_hash: done, errors");
        $finish;
    end

endmodule
